// ===== src/msdl_pkg.sv =====
// Shared types and constants of the multichannel sample delay line.
package msdl_pkg;

   // Configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   // Register field widths
   localparam int CH_COUNT_W = 3;
   localparam int DELAY_W    = 12;
   localparam int CHANNEL_W  = 2;
   localparam int DELAY_REGS = 4;

   // Largest delay a register can hold
   localparam int DELAY_MAX = 4095;

   // Register reset values
   localparam logic [CH_COUNT_W-1:0] CH_COUNT_RESET  = 3'd2;
   localparam logic [DELAY_W-1:0]    MAX_DELAY_RESET = 12'd4095;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 3'd0,
      CSR_MAX_DELAY     = 3'd1,
      CSR_DELAY_CH0     = 3'd2,
      CSR_DELAY_CH1     = 3'd3,
      CSR_DELAY_CH2     = 3'd4,
      CSR_DELAY_CH3     = 3'd5
   } csr_index_type;

endpackage

// ===== src/msdl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module msdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write; holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/multichannel_sample_delay_line.sv =====
// Multichannel sample delay line: round-robin channels over a circular frame store.
// Stages: clamp and upper reduction at the sample transfer into s1, lower reduction
// and read frame into s2, then the RAM read and the output register; the split modulo
// reduction and the registered RAM read set these stages. Throughput: one sample
// per cycle unless stalled, with one RAM write and one RAM read per sample.
// Reset: synchronous; afterwards a clearing pass writes zero to all
// FRAME_DEPTH*MAX_CHANNELS RAM words, one per cycle, with req_stall held high.
module multichannel_sample_delay_line
   import msdl_pkg::*;
#(
   parameter int MAX_CHANNELS = 4,
   parameter int FRAME_DEPTH  = 4096,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample_in,
   // delayed sample output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [CHANNEL_W-1:0]   rsp_channel,
   output logic                   rsp_frame_end,
   // configuration writes
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int FW          = $clog2(FRAME_DEPTH);
   localparam int STORE_WORDS = FRAME_DEPTH * MAX_CHANNELS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int EW          = ((FW > DELAY_W) ? FW : DELAY_W) + 1;
   localparam int MOD_SPLIT   = 6;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [CH_W-1:0]        ch;
      logic                   last;
      logic [FW-1:0]          wf;
      logic [DELAY_W-1:0]     dr;
   } s1_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [CH_W-1:0]        ch;
      logic                   last;
      logic [FW-1:0]          wf;
      logic [FW-1:0]          rf;
   } s2_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [CH_W-1:0]        ch;
      logic                   last;
      logic                   fwd;
   } out_type;

   // Configuration registers
   logic [CH_COUNT_W-1:0] channel_count_ff;
   logic [DELAY_W-1:0]    max_delay_ff;
   logic [DELAY_W-1:0]    delay_ff [DELAY_REGS];

   // Sequencing state
   logic [CH_W-1:0] channel_index_ff, channel_index_in;
   logic [FW-1:0]   write_frame_ff, write_frame_in;

   // Clearing pass
   logic              clear_active_ff, clear_active_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // Pipeline
   logic    v1_ff, v2_ff, rsp_valid_ff;
   logic    v1_in, v2_in, rsp_valid_in;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   out_type out_ff, out_in;
   logic    ready1, ready2, ready_out;
   logic    accept, move2;

   // Accept-stage logic
   logic [CH_COUNT_W-1:0] active_n;
   logic                  last_now;
   logic [DELAY_W-1:0]    limit, delay_sel, delay_clamped, delay_high;
   logic [DELAY_W-1:0]    delay_mod;
   logic [EW-1:0]         wf_ext, dm_ext, rf_ext;

   // RAM ports
   logic                   mem_we, mem_re;
   logic [ADDR_W-1:0]      mem_wr_addr, mem_rd_addr;
   logic [SAMPLE_BITS-1:0] mem_wr_data, mem_rd_data;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CH_COUNT_RESET;
         max_delay_ff     <= MAX_DELAY_RESET;
         for (int i = 0; i < DELAY_REGS; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CH_COUNT_W-1:0];
            CSR_MAX_DELAY:     max_delay_ff     <= csr_data[DELAY_W-1:0];
            CSR_DELAY_CH0:     delay_ff[0]      <= csr_data[DELAY_W-1:0];
            CSR_DELAY_CH1:     delay_ff[1]      <= csr_data[DELAY_W-1:0];
            CSR_DELAY_CH2:     delay_ff[2]      <= csr_data[DELAY_W-1:0];
            CSR_DELAY_CH3:     delay_ff[3]      <= csr_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: each stage loads when empty or when it drains downstream
   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !v2_ff || ready_out;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = clear_active_ff || !ready1;
   assign accept    = req_valid && !req_stall;
   assign move2     = v2_ff && ready_out;

   // Channel count limited to 1..MAX_CHANNELS, end of frame detect
   always_comb begin
      if (channel_count_ff == '0) begin
         active_n = CH_COUNT_W'(1);
      end else if (channel_count_ff > CH_COUNT_W'(MAX_CHANNELS)) begin
         active_n = CH_COUNT_W'(MAX_CHANNELS);
      end else begin
         active_n = channel_count_ff;
      end
      last_now = (CH_COUNT_W'(channel_index_ff) + CH_COUNT_W'(1)) >= active_n;
   end

   // Channel and frame sequencing on each transfer
   always_comb begin
      channel_index_in = channel_index_ff;
      write_frame_in   = write_frame_ff;
      if (accept) begin
         if (last_now) begin
            channel_index_in = '0;
            write_frame_in   = (write_frame_ff == FW'(FRAME_DEPTH - 1)) ? '0
                                                                         : write_frame_ff + 1'b1;
         end else begin
            channel_index_in = channel_index_ff + 1'b1;
         end
      end
   end

   // Delay limit, then upper half of the reduction modulo FRAME_DEPTH
   always_comb begin
      limit         = (max_delay_ff == '0) ? DELAY_W'(1) : max_delay_ff;
      delay_sel     = delay_ff[2'(channel_index_ff)];
      delay_clamped = (delay_sel > limit) ? limit : delay_sel;
      delay_high    = delay_clamped;
      for (int k = DELAY_W - 1; k >= MOD_SPLIT; k--) begin
         if ((FRAME_DEPTH << k) <= DELAY_MAX) begin
            if (delay_high >= DELAY_W'(FRAME_DEPTH << k)) begin
               delay_high = delay_high - DELAY_W'(FRAME_DEPTH << k);
            end
         end
      end
      s1_in.sample = req_sample_in;
      s1_in.ch     = channel_index_ff;
      s1_in.last   = last_now;
      s1_in.wf     = write_frame_ff;
      s1_in.dr     = delay_high;
   end

   // Lower half of the reduction, then the read frame
   always_comb begin
      delay_mod = s1_ff.dr;
      for (int k = MOD_SPLIT - 1; k >= 0; k--) begin
         if ((FRAME_DEPTH << k) <= DELAY_MAX) begin
            if (delay_mod >= DELAY_W'(FRAME_DEPTH << k)) begin
               delay_mod = delay_mod - DELAY_W'(FRAME_DEPTH << k);
            end
         end
      end
      wf_ext = EW'(s1_ff.wf);
      dm_ext = EW'(delay_mod);
      rf_ext = (wf_ext >= dm_ext) ? (wf_ext - dm_ext) : (wf_ext + EW'(FRAME_DEPTH) - dm_ext);
      s2_in.sample = s1_ff.sample;
      s2_in.ch     = s1_ff.ch;
      s2_in.last   = s1_ff.last;
      s2_in.wf     = s1_ff.wf;
      s2_in.rf     = FW'(rf_ext);
   end

   // Output stage: forward the fresh sample when read and write hit one word
   always_comb begin
      out_in.sample = s2_ff.sample;
      out_in.ch     = s2_ff.ch;
      out_in.last   = s2_ff.last;
      out_in.fwd    = (s2_ff.rf == s2_ff.wf);
   end

   // Valid bits
   always_comb begin
      v1_in        = ready1 ? accept : v1_ff;
      v2_in        = ready2 ? v1_ff : v2_ff;
      rsp_valid_in = ready_out ? v2_ff : rsp_valid_ff;
   end

   // Clearing pass sweep
   always_comb begin
      clear_active_in = clear_active_ff;
      clear_addr_in   = clear_addr_ff;
      if (clear_active_ff) begin
         if (clear_addr_ff == ADDR_W'(STORE_WORDS - 1)) begin
            clear_active_in = 1'b0;
         end else begin
            clear_addr_in = clear_addr_ff + 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_index_ff <= '0;
         write_frame_ff   <= '0;
         clear_active_ff  <= 1'b1;
         clear_addr_ff    <= '0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         channel_index_ff <= channel_index_in;
         write_frame_ff   <= write_frame_in;
         clear_active_ff  <= clear_active_in;
         clear_addr_ff    <= clear_addr_in;
         v1_ff            <= v1_in;
         v2_ff            <= v2_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (v1_ff && ready2) begin
         s2_ff <= s2_in;
      end
      if (move2) begin
         out_ff <= out_in;
      end
   end

   // RAM write and read of one sample happen in the same cycle
   always_comb begin
      mem_wr_addr = ADDR_W'(s2_ff.wf) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(s2_ff.ch);
      mem_rd_addr = ADDR_W'(s2_ff.rf) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(s2_ff.ch);
      mem_wr_data = s2_ff.sample;
      mem_we      = move2;
      mem_re      = move2;
      if (clear_active_ff) begin
         mem_wr_addr = clear_addr_ff;
         mem_wr_data = '0;
         mem_we      = 1'b1;
      end
   end

   msdl_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_WORDS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_re),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Outputs
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff.fwd ? out_ff.sample : mem_rd_data;
   assign rsp_channel    = CHANNEL_W'(out_ff.ch);
   assign rsp_frame_end  = out_ff.last;

   // The pipeline stays empty while the store is being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !(v1_ff || v2_ff || rsp_valid_ff))
      else $error("sample in flight during clearing pass");

   // A RAM read always produces a result in the next cycle
   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      move2 |=> rsp_valid_ff)
      else $error("RAM read without result");

   // A held result keeps its read data: no RAM read while the output is stalled
   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !mem_re)
      else $error("RAM read data overwritten under stall");

endmodule

// ===== verif/msdl_delay_checker.sv =====
// Checker for the multichannel sample delay line: predicts each delayed sample and compares.
`timescale 1ns / 100ps

module msdl_delay_checker
   import msdl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [23:0]            req_sample_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [23:0]            rsp_sample_out,
   input  logic [CHANNEL_W-1:0]   rsp_channel,
   input  logic                   rsp_frame_end,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     outstanding,
   output int                     fail_count
);

   localparam int STORE_FRAMES = 4096;
   localparam int FRAME_SLOTS  = 4;

   typedef struct packed {
      logic [23:0]          sample;
      logic [CHANNEL_W-1:0] channel;
      logic                 frame_end;
   } delayed_sample_type;

   // Local copy of the block state and its settings
   logic [23:0]           frame_mem [0:STORE_FRAMES*FRAME_SLOTS-1];
   logic [DELAY_W-1:0]    write_frame;
   logic [CHANNEL_W-1:0]  next_channel;
   logic [CH_COUNT_W-1:0] chan_count_reg;
   logic [DELAY_W-1:0]    max_delay_reg;
   logic [DELAY_W-1:0]    delay_reg [DELAY_REGS];

   delayed_sample_type delayed_q[$];

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Write one sample into the store and fetch the one from this channel's delay ago
   task automatic predict_delayed(input logic [23:0] s, output delayed_sample_type r);
      int                    active;
      logic [DELAY_W-1:0]    lim;
      logic [DELAY_W-1:0]    dly;
      logic [DELAY_W-1:0]    read_frame;
      logic [CHANNEL_W-1:0]  ch;
      active = chan_count_reg;
      if (active < 1) active = 1;
      if (active > FRAME_SLOTS) active = FRAME_SLOTS;
      ch = next_channel;
      lim = (max_delay_reg == '0) ? DELAY_W'(1) : max_delay_reg;
      dly = (delay_reg[ch] > lim) ? lim : delay_reg[ch];
      read_frame = write_frame - dly;   // wraps around the store
      frame_mem[{write_frame, ch}] = s;
      r.sample    = frame_mem[{read_frame, ch}];
      r.channel   = ch;
      r.frame_end = (int'(ch) + 1 >= active);
      if (r.frame_end) begin
         next_channel = '0;
         write_frame  = write_frame + 1'b1;
      end else begin
         next_channel = ch + 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      delayed_sample_type want;
      if (reset) begin
         chan_count_reg = CH_COUNT_RESET;
         max_delay_reg  = MAX_DELAY_RESET;
         for (int i = 0; i < DELAY_REGS; i++) delay_reg[i] = '0;
         for (int i = 0; i < STORE_FRAMES*FRAME_SLOTS; i++) frame_mem[i] = '0;
         write_frame  = '0;
         next_channel = '0;
         delayed_q.delete();
      end else begin
         // register writes; unknown indexes fall through
         if (csr_write) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: chan_count_reg = csr_data[CH_COUNT_W-1:0];
               CSR_MAX_DELAY:     max_delay_reg  = csr_data[DELAY_W-1:0];
               CSR_DELAY_CH0:     delay_reg[0]   = csr_data[DELAY_W-1:0];
               CSR_DELAY_CH1:     delay_reg[1]   = csr_data[DELAY_W-1:0];
               CSR_DELAY_CH2:     delay_reg[2]   = csr_data[DELAY_W-1:0];
               CSR_DELAY_CH3:     delay_reg[3]   = csr_data[DELAY_W-1:0];
               default: ;
            endcase
         end
         // sample transfer in
         if (req_valid && !req_stall) begin
            predict_delayed(req_sample_in, want);
            delayed_q.push_back(want);
         end
         // result transfer out
         if (rsp_valid && !rsp_stall) begin
            if (delayed_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result sample %h channel %0d end %b",
                  rsp_sample_out, rsp_channel, rsp_frame_end));
            end else begin
               want = delayed_q.pop_front();
               if (rsp_sample_out !== want.sample)
                  report_mismatch($sformatf("sample_out %h, predicted %h",
                     rsp_sample_out, want.sample));
               if (rsp_channel !== want.channel)
                  report_mismatch($sformatf("channel %0d, predicted %0d",
                     rsp_channel, want.channel));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, predicted %b",
                     rsp_frame_end, want.frame_end));
            end
         end
      end
      outstanding <= delayed_q.size();
   end

endmodule

// ===== verif/tb_multichannel_sample_delay_line.sv =====
// Testbench top for the multichannel sample delay line: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_multichannel_sample_delay_line;
   import msdl_pkg::*;

   localparam int RANDOM_ITEMS    = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_SLACK     = 8;

   // indexes past the last register, must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [23:0]            req_sample_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [23:0]            rsp_sample_out;
   logic [CHANNEL_W-1:0]   rsp_channel;
   logic                   rsp_frame_end;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   hold_off_req = 1'b0;
   int                     outstanding;
   int                     fail_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   multichannel_sample_delay_line dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_channel    (rsp_channel),
      .rsp_frame_end  (rsp_frame_end),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   msdl_delay_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_channel    (rsp_channel),
      .rsp_frame_end  (rsp_frame_end),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .outstanding    (outstanding),
      .fail_count     (fail_count)
   );

   // One register write, taken at the next edge
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Offer one sample and hold it until the transfer
   task automatic send_sample(input logic [23:0] s);
      req_valid     <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Wait until every predicted result has come back
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [23:0] next_audio_sample();
      logic [23:0] s;
      s = 24'($urandom());
      case ($urandom_range(0, 15))
         0: s = 24'h7FFFFF;
         1: s = 24'h800000;
         2: s = 24'h000000;
         3: s = 24'hFFFFFF;
         default: ;
      endcase
      return s;
   endfunction

   // Random samples in bursts, optionally with gaps between them
   task automatic run_samples(input int count, input bit with_gaps);
      int burst_left;
      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < count; i++) begin
         send_sample(next_audio_sample());
         if (with_gaps) begin
            burst_left--;
            if (burst_left == 0) begin
               idle_sender($urandom_range(1, 6));
               burst_left = $urandom_range(1, 24);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   function automatic logic [DELAY_W-1:0] pick_delay();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return DELAY_W'($urandom_range(0, 6));
         6, 7:             return DELAY_W'($urandom_range(0, 64));
         8:                return DELAY_W'(DELAY_MAX);
         default:          return DELAY_W'($urandom_range(0, DELAY_MAX));
      endcase
   endfunction

   // New settings for a random phase; mostly useful counts and short delays
   task automatic randomize_settings();
      logic [CSR_DATA_W-1:0] value;
      value = CSR_DATA_W'($urandom());
      if ($urandom_range(0, 9) < 8)
         value[CH_COUNT_W-1:0] = CH_COUNT_W'($urandom_range(1, 4));
      write_reg(CSR_CHANNEL_COUNT, value);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: value = DELAY_W'(DELAY_MAX);
         6, 7:             value = DELAY_W'($urandom_range(0, 8));
         8:                value = '0;
         default:          value = CSR_DATA_W'($urandom());
      endcase
      write_reg(CSR_MAX_DELAY, value);
      write_reg(CSR_DELAY_CH0, pick_delay());
      write_reg(CSR_DELAY_CH1, pick_delay());
      write_reg(CSR_DELAY_CH2, pick_delay());
      write_reg(CSR_DELAY_CH3, pick_delay());
      if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE_LO, CSR_DATA_W'($urandom()));
   endtask

   // Receiver: a new random stall pattern for each span, long hold-off on request
   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            if (hold_off_req) begin
               hold_off_req <= 1'b0;
               rsp_stall    <= 1'b1;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               rsp_stall    <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 9) < 8);
                  default: rsp_stall <= (i % 4 != 0);
               endcase
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int sent;
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: two channels, zero delay, so each sample echoes back
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'h000000);
      send_sample(24'hFFFFFF);
      send_sample(24'h555555);
      send_sample(24'hAAAAAA);
      req_valid <= 1'b0;
      wait_drained();

      // four channels, a different delay on each; stop mid-frame
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(4));
      write_reg(CSR_DELAY_CH0, DELAY_W'(1));
      write_reg(CSR_DELAY_CH1, DELAY_W'(2));
      write_reg(CSR_DELAY_CH2, DELAY_W'(3));
      write_reg(CSR_DELAY_CH3, DELAY_W'(0));
      run_samples(7, 1'b0);
      wait_drained();

      // count of zero acts as one and ends the open frame; max delay of zero acts as one
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(0));
      write_reg(CSR_MAX_DELAY, CSR_DATA_W'(0));
      write_reg(CSR_DELAY_CH0, DELAY_W'(DELAY_MAX));
      run_samples(4, 1'b0);
      wait_drained();

      // count beyond four with junk in the upper data bits, longest delays, spare indexes
      write_reg(CSR_CHANNEL_COUNT, {9'h1FF, 3'd7});
      write_reg(CSR_MAX_DELAY, DELAY_W'(DELAY_MAX));
      write_reg(CSR_DELAY_CH0, DELAY_W'(DELAY_MAX));
      write_reg(CSR_DELAY_CH1, DELAY_W'(DELAY_MAX));
      write_reg(CSR_DELAY_CH2, DELAY_W'(DELAY_MAX));
      write_reg(CSR_DELAY_CH3, DELAY_W'(DELAY_MAX));
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '1);
      run_samples(5, 1'b0);
      wait_drained();

      // random phases with fresh settings each time
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         int count;
         randomize_settings();
         count = $urandom_range(20, 120);
         if (phase == 2) begin
            // receiver holds off while samples keep coming back to back
            hold_off_req <= 1'b1;
            run_samples(count, 1'b0);
         end else begin
            run_samples(count, $urandom_range(0, 3) != 0);
         end
         sent += count;
         phase++;
         wait_drained();
      end

      repeat (DRAIN_SLACK) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Run limit: covers the store clearing pass and heavy stalling many times over
   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
